// ----- src/second_slot_seek_index_core_macros.svh -----
// Assertion macros shared by the seek index RTL.
`ifndef SECOND_SLOT_SEEK_INDEX_CORE_MACROS_SVH
`define SECOND_SLOT_SEEK_INDEX_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("seek index assertion failed");

// Next-cycle implication, disabled during reset.
`define SSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("seek index assertion failed");

`endif

// ----- src/ssi_pkg.sv -----
// Shared types and constants of the second slot seek index.
`default_nettype none
package ssi_pkg;

   localparam int OPCODE_W       = 2;
   localparam int TIME_W         = 31;
   localparam int OFFSET_W       = 63;
   localparam int STATUS_W       = 3;
   localparam int COUNT_W        = 8;
   localparam int ENTRY_W        = TIME_W + OFFSET_W;
   localparam int PERIOD_DEFAULT = 86400;

   localparam logic [COUNT_W-1:0] FLUSH_RESET = 8'd10;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_FIRST  = 2'd1,
      OP_LAST   = 2'd2,
      OP_LOOKUP = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_ZERO   = 3'd1,
      STATUS_TAKEN  = 3'd2,
      STATUS_EMPTY  = 3'd3,
      STATUS_NOT_IN = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_REM,
      ST_READ,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- src/second_slot_seek_index_core.sv -----
// Top level of the second slot seek index: sequencer, counters and result register.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   req     | in  | req_valid/stall    | opcode, entry_time, entry_offset
//   rsp     | out | rsp_valid/stall    | status, found_time, found_offset, persist
//   csr     | in  | csr_write_enable   | flush_interval (8 bit)
//
// Each beat steps through ST_MUL and ST_REM for the time modulo period multiplier
// pipeline, ST_READ for the slot memory read and ST_DONE to decide, write back and
// load the result. After reset all SECONDS_PER_PERIOD slots are cleared, one
// slot per cycle, with req_stall held high; csr writes are taken throughout.
// A waiting result does not block the next beat, but a second result waits in
// the decide step until the result register frees up.
// Lowest and highest occupied slots are tracked in registers (slots are never
// freed), so get-first and get-last need a single memory read.
`default_nettype none
`include "second_slot_seek_index_core_macros.svh"
module second_slot_seek_index_core #(
   parameter int SECONDS_PER_PERIOD = ssi_pkg::PERIOD_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ssi_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [ssi_pkg::TIME_W-1:0]    req_entry_time,
   input  wire logic [ssi_pkg::OFFSET_W-1:0]  req_entry_offset,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [ssi_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [ssi_pkg::TIME_W-1:0]    rsp_found_time,
   output logic      [ssi_pkg::OFFSET_W-1:0]  rsp_found_offset,
   output logic                               rsp_persist_request,
   // configuration
   input  wire logic                          csr_write_enable,
   input  wire logic [ssi_pkg::COUNT_W-1:0]   csr_write_data
);
   import ssi_pkg::*;

   localparam int SLOT_W = $clog2(SECONDS_PER_PERIOD);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SECONDS_PER_PERIOD - 1);

   // sequencer
   state_type state_ff, state_in;

   // captured request beat
   opcode_type        op_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [OFFSET_W-1:0] offset_ff;

   // control state
   logic [SLOT_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic [COUNT_W-1:0]  flush_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                any_ff, any_in;
   logic [SLOT_W-1:0]   min_ff, min_in;
   logic [SLOT_W-1:0]   max_ff, max_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff;
   logic [TIME_W-1:0]   found_time_ff;
   logic [OFFSET_W-1:0] found_offset_ff;
   logic                persist_ff;

   // datapath
   logic [SLOT_W-1:0]   mod_slot;
   logic                ram_we;
   logic [SLOT_W-1:0]   ram_addr;
   logic [SLOT_W-1:0]   read_addr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic [TIME_W-1:0]   rd_time;
   logic [OFFSET_W-1:0] rd_offset;

   // decide step
   logic                out_free;
   logic                take_req;
   logic                finish;
   logic                insert_ok;
   logic                zero_field;
   logic [COUNT_W-1:0]  count_inc;
   logic                persist_hit;
   status_type          status_res;
   logic [TIME_W-1:0]   found_time_res;
   logic [OFFSET_W-1:0] found_offset_res;
   logic                persist_res;

   ssi_slot_mod #(
      .PERIOD (SECONDS_PER_PERIOD),
      .SLOT_W (SLOT_W)
   ) u_mod (
      .clock      (clock),
      .entry_time (time_ff),
      .slot       (mod_slot)
   );

   ssi_slot_ram #(
      .DEPTH  (SECONDS_PER_PERIOD),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .addr         (ram_addr),
      .write_data   (ram_wdata),
      .read_data    (ram_rdata)
   );

   assign rd_time   = ram_rdata[OFFSET_W +: TIME_W];
   assign rd_offset = ram_rdata[OFFSET_W-1:0];

   // get-first/get-last read the tracked bounds, the others the hashed slot
   always_comb begin
      case (op_ff)
         OP_FIRST: read_addr = min_ff;
         OP_LAST:  read_addr = max_ff;
         default:  read_addr = mod_slot;
      endcase
   end

   // decide on the read entry
   assign zero_field  = (time_ff == '0) || (offset_ff == '0);
   assign count_inc   = count_ff + COUNT_W'(1);
   assign persist_hit = (count_inc >= flush_ff);

   always_comb begin
      insert_ok        = 1'b0;
      status_res       = STATUS_OK;
      found_time_res   = '0;
      found_offset_res = '0;
      persist_res      = 1'b0;
      unique case (op_ff)
         OP_INSERT: begin
            if (zero_field) begin
               status_res = STATUS_ZERO;
            end else if (rd_offset != '0) begin
               status_res = STATUS_TAKEN;
            end else begin
               insert_ok   = 1'b1;
               persist_res = persist_hit;
            end
         end
         OP_FIRST, OP_LAST: begin
            if (any_ff) begin
               found_time_res   = rd_time;
               found_offset_res = rd_offset;
            end else begin
               status_res = STATUS_EMPTY;
            end
         end
         OP_LOOKUP: begin
            // same remainder, so same period iff the times are equal
            if (rd_time != '0 && rd_offset != '0 && rd_time == time_ff) begin
               found_time_res   = rd_time;
               found_offset_res = rd_offset;
            end else begin
               status_res = STATUS_NOT_IN;
            end
         end
         default: status_res = STATUS_OK;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clear_cnt_ff == LAST_SLOT) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_REM;
         ST_REM:   state_in = ST_READ;
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = req_valid ? ST_MUL : ST_IDLE;
            end
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      finish    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = read_addr;
      ram_wdata = {time_ff, offset_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clear_cnt_ff;
            ram_wdata = '0;
         end
         ST_IDLE: req_stall = 1'b0;
         ST_DONE: begin
            req_stall = !out_free;
            finish    = out_free;
            ram_we    = out_free && insert_ok;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign take_req = req_valid && !req_stall;

   // counters, bounds and result
   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      count_in     = count_ff;
      any_in       = any_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_CLEAR) begin
         clear_cnt_in = clear_cnt_ff + SLOT_W'(1);
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
      if (finish && insert_ok) begin
         count_in = persist_hit ? '0 : count_inc;
         any_in   = 1'b1;
         if (!any_ff || mod_slot < min_ff) min_in = mod_slot;
         if (!any_ff || mod_slot > max_ff) max_in = mod_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         flush_ff     <= FLUSH_RESET;
         count_ff     <= '0;
         any_ff       <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         count_ff     <= count_in;
         any_ff       <= any_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            flush_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         op_ff     <= opcode_type'(req_opcode);
         time_ff   <= req_entry_time;
         offset_ff <= req_entry_offset;
      end
      if (finish) begin
         status_ff       <= status_res;
         found_time_ff   <= found_time_res;
         found_offset_ff <= found_offset_res;
         persist_ff      <= persist_res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_found_time      = found_time_ff;
   assign rsp_found_offset    = found_offset_ff;
   assign rsp_persist_request = persist_ff;

   // memory is only written by the clearing pass or a decided insert
   `SSI_ASSERT_NOW(a_write_source, clock, reset, ram_we, (state_ff == ST_CLEAR || finish))
   // no result appears while the memory is still being cleared
   `SSI_ASSERT_NOW(a_no_rsp_in_clear, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)
   // tracked bounds stay ordered once a slot is occupied
   `SSI_ASSERT_NOW(a_bounds_ordered, clock, reset, any_ff, min_ff <= max_ff)
   // a persist request only ever rides on a successful insert
   `SSI_ASSERT_NOW(a_persist_ok, clock, reset, rsp_valid_ff && rsp_persist_request,
      rsp_status == STATUS_OK)
   // a finished beat always shows up as a pending result
   `SSI_ASSERT_NEXT(a_finish_shows, clock, reset, finish, rsp_valid_ff)

endmodule
`default_nettype wire

// ----- src/ssi_slot_mod.sv -----
// Two-stage pipelined time modulo period (reciprocal multiply).
`default_nettype none
module ssi_slot_mod #(
   parameter int PERIOD = ssi_pkg::PERIOD_DEFAULT,
   parameter int SLOT_W = $clog2(PERIOD)
) (
   input  wire logic                      clock,
   input  wire logic [ssi_pkg::TIME_W-1:0] entry_time,
   output logic      [SLOT_W-1:0]          slot
);
   import ssi_pkg::*;

   localparam int SHIFT   = TIME_W + SLOT_W;
   localparam int MAGIC_W = TIME_W + 2;
   localparam int QUOT_W  = TIME_W + 1 - SLOT_W;
   localparam int PROD_W  = TIME_W + MAGIC_W;
   localparam logic [63:0] MAGIC_WIDE =
      ((64'd1 << SHIFT) + 64'(PERIOD) - 64'd1) / 64'(PERIOD);
   localparam logic [MAGIC_W-1:0] MAGIC = MAGIC_WIDE[MAGIC_W-1:0];

   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] quot_ff;
   logic [TIME_W-1:0] time_d_ff;
   logic [TIME_W:0]   quot_scaled;
   logic [TIME_W:0]   diff;
   logic [SLOT_W-1:0] slot_ff;

   // stage 1: quotient = floor(t * MAGIC / 2^SHIFT), exact for all 31-bit t
   assign prod = PROD_W'(entry_time) * PROD_W'(MAGIC);

   always_ff @(posedge clock) begin
      quot_ff   <= prod[SHIFT +: QUOT_W];
      time_d_ff <= entry_time;
   end

   // stage 2: remainder = t - quotient * period
   assign quot_scaled = (TIME_W+1)'(quot_ff) * (TIME_W+1)'(PERIOD);
   assign diff        = {1'b0, time_d_ff} - quot_scaled;

   always_ff @(posedge clock) begin
      slot_ff <= diff[SLOT_W-1:0];
   end

   assign slot = slot_ff;

endmodule
`default_nettype wire

// ----- src/ssi_slot_ram.sv -----
// Single-port slot memory with registered read data.
`default_nettype none
module ssi_slot_ram #(
   parameter int DEPTH  = ssi_pkg::PERIOD_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       write_enable,
   input  wire logic [ADDR_W-1:0]          addr,
   input  wire logic [ssi_pkg::ENTRY_W-1:0] write_data,
   output logic      [ssi_pkg::ENTRY_W-1:0] read_data
);
   import ssi_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[addr] <= write_data;
      end
      read_data_ff <= mem[addr];
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

// ----- verif/second_slot_seek_index_core_tb.sv -----
// Self-checking testbench for the second slot seek index core.
`default_nettype none
module second_slot_seek_index_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssi_pkg::*;

   localparam int PERIOD      = PERIOD_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;     // the clear pass over all PERIOD slots must fit in it
   localparam int HOT_SLOTS   = 8;
   localparam int REPORT_MAX  = 10;
   localparam logic [TIME_W-1:0]   STAMP_MAX  = '1;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
   localparam int unsigned DAY_MAX = STAMP_MAX / PERIOD;

   // one result beat as the block should produce it
   typedef struct packed {
      status_type            status;
      logic [TIME_W-1:0]     found_stamp;
      logic [OFFSET_W-1:0]   found_offs;
      logic                  persist;
   } seek_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OPCODE_W-1:0]   req_opcode = OP_FIRST;
   logic [TIME_W-1:0]     req_entry_time = '0;
   logic [OFFSET_W-1:0]   req_entry_offset = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [TIME_W-1:0]     rsp_found_time;
   logic [OFFSET_W-1:0]   rsp_found_offset;
   logic                  rsp_persist_request;
   logic                  csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]    csr_write_data = '0;

   second_slot_seek_index_core #(
      .SECONDS_PER_PERIOD(PERIOD)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_entry_time      (req_entry_time),
      .req_entry_offset    (req_entry_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_found_time      (rsp_found_time),
      .rsp_found_offset    (rsp_found_offset),
      .rsp_persist_request (rsp_persist_request),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predicted index contents. Slots are never freed, so the lowest and
   // highest occupied slot are tracked as running bounds instead of
   // scanning the whole day on every get-first / get-last.
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0]     slot_stamp_m [PERIOD];
   logic [OFFSET_W-1:0]   slot_offs_m  [PERIOD];
   logic [COUNT_W-1:0]    insert_tally = '0;
   logic [COUNT_W-1:0]    flush_setting = FLUSH_RESET;
   bit                    any_occupied = 1'b0;
   int unsigned           low_slot = 0;
   int unsigned           high_slot = 0;
   logic [TIME_W-1:0]     placed_stamps [$];

   seek_result_type       expected_results [$];

   // stimulus knobs and bookkeeping
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_left = 0;
   int          reach = 200;        // upper bound of wide slot picks, grows with the run
   int unsigned hot_slot [HOT_SLOTS];
   int          beats_sent = 0;
   int          results_checked = 0;
   int          persists_due = 0;
   int          fail_count = 0;
   int          cycle_count = 0;

   initial begin
      foreach (slot_stamp_m[i]) begin
         slot_stamp_m[i] = '0;
         slot_offs_m[i] = '0;
      end
   end

   function automatic seek_result_type predict_seek(input opcode_type op,
                                                    input logic [TIME_W-1:0] stamp,
                                                    input logic [OFFSET_W-1:0] offs);
      seek_result_type res;
      int unsigned slot;
      int unsigned pick;
      res = '0;
      res.status = STATUS_OK;
      slot = stamp % PERIOD;
      case (op)
         OP_INSERT: begin
            if (stamp == '0 || offs == '0) begin
               res.status = STATUS_ZERO;
            end else if (slot_offs_m[slot] != '0) begin
               res.status = STATUS_TAKEN;
            end else begin
               slot_stamp_m[slot] = stamp;
               slot_offs_m[slot] = offs;
               placed_stamps.push_back(stamp);
               if (!any_occupied || slot < low_slot) low_slot = slot;
               if (!any_occupied || slot > high_slot) high_slot = slot;
               any_occupied = 1'b1;
               insert_tally = insert_tally + COUNT_W'(1);
               // flush setting of zero fires on every insert
               if (insert_tally >= flush_setting) begin
                  insert_tally = '0;
                  res.persist = 1'b1;
               end
            end
         end
         OP_FIRST, OP_LAST: begin
            if (!any_occupied) begin
               res.status = STATUS_EMPTY;
            end else begin
               pick = (op == OP_FIRST) ? low_slot : high_slot;
               res.found_stamp = slot_stamp_m[pick];
               res.found_offs = slot_offs_m[pick];
            end
         end
         default: begin
            // lookup hits only when the slot holds an entry of the same day
            if (slot_stamp_m[slot] != '0 && slot_offs_m[slot] != '0 &&
                slot_stamp_m[slot] / PERIOD == stamp / PERIOD) begin
               res.found_stamp = slot_stamp_m[slot];
               res.found_offs = slot_offs_m[slot];
            end else begin
               res.status = STATUS_NOT_IN;
            end
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid is left high after a beat is taken so that
   // back-to-back beats never lower and raise it in the same step.
   // ---------------------------------------------------------------------
   task automatic send_beat(input opcode_type op, input logic [TIME_W-1:0] stamp,
                            input logic [OFFSET_W-1:0] offs);
      seek_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_time <= stamp;
      req_entry_offset <= offs;
      do @(posedge clock); while (req_stall !== 1'b0);
      res = predict_seek(op, stamp, offs);
      if (res.persist) persists_due++;
      expected_results.push_back(res);
      beats_sent++;
   endtask

   // idle the request side until every pending result is back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_flush(input logic [COUNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      flush_setting = value;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Random field pickers. Slots come from a small hot set (to hit taken
   // slots and other-day entries) or from a range that widens as the run
   // goes on, so get-last keeps moving. The top slot is held back.
   // ---------------------------------------------------------------------
   function automatic logic [TIME_W-1:0] pick_stamp();
      longint unsigned slot, day, full;
      if ($urandom_range(99) < 40) slot = hot_slot[$urandom_range(HOT_SLOTS-1)];
      else slot = $urandom_range(reach);
      case ($urandom_range(3))
         0:       day = $urandom_range(3);
         1:       day = DAY_MAX - $urandom_range(2);
         default: day = $urandom_range(DAY_MAX);
      endcase
      full = day * PERIOD + slot;
      if (full > STAMP_MAX) full = full - PERIOD;
      return TIME_W'(full);
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset();
      logic [63:0] raw;
      case ($urandom_range(9))
         0:       raw = 64'(1 + $urandom_range(3));
         1:       raw = {1'b0, OFFSET_MAX};
         default: raw = {$urandom, $urandom};
      endcase
      if (raw[OFFSET_W-1:0] == '0) raw = 64'd1;
      return raw[OFFSET_W-1:0];
   endfunction

   task automatic random_beat();
      int unsigned roll;
      logic [TIME_W-1:0] stamp;
      roll = $urandom_range(99);
      if (roll < 45) begin
         if ($urandom_range(99) < 8) begin
            if ($urandom_range(1) == 0) send_beat(OP_INSERT, '0, pick_offset());
            else send_beat(OP_INSERT, pick_stamp(), '0);
         end else begin
            send_beat(OP_INSERT, pick_stamp(), pick_offset());
         end
      end else if (roll < 75) begin
         roll = $urandom_range(3);
         if (roll < 2 && placed_stamps.size() != 0) begin
            stamp = placed_stamps[$urandom_range(placed_stamps.size()-1)];
            // same slot, another day: must miss
            if (roll == 1) stamp = (stamp > STAMP_MAX - PERIOD) ?
                                   TIME_W'(stamp - PERIOD) : TIME_W'(stamp + PERIOD);
         end else begin
            stamp = pick_stamp();
         end
         send_beat(OP_LOOKUP, stamp, pick_offset());
      end else if (roll < 87) begin
         send_beat(OP_FIRST, TIME_W'($urandom), pick_offset());
      end else begin
         send_beat(OP_LAST, TIME_W'($urandom), pick_offset());
      end
      if (reach + PERIOD / 600 < PERIOD - 2) reach = reach + PERIOD / 600;
      else reach = PERIOD - 2;
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [COUNT_W-1:0] flush, input int beats);
      pause_until_drained();
      write_flush(flush);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (beats) random_beat();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty table, zero fields, slot 0 seen by get-last, other-day misses,
   // field extremes, and a persist at the reset flush interval.
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_beat(OP_FIRST, '0, '0);
      send_beat(OP_LAST, STAMP_MAX, OFFSET_MAX);
      send_beat(OP_LOOKUP, '0, '0);
      send_beat(OP_INSERT, '0, 63'd5);
      send_beat(OP_INSERT, 31'd5, '0);
      send_beat(OP_INSERT, TIME_W'(PERIOD * 3), OFFSET_MAX);
      send_beat(OP_LAST, '0, '0);           // only slot 0 is occupied
      send_beat(OP_FIRST, '0, '0);
      send_beat(OP_LOOKUP, TIME_W'(PERIOD * 3), '0);
      send_beat(OP_LOOKUP, TIME_W'(PERIOD * 4), '0);
      send_beat(OP_INSERT, TIME_W'(PERIOD * 7), 63'd1);   // slot 0 already taken
      send_beat(OP_INSERT, STAMP_MAX, 63'd1);
      send_beat(OP_LOOKUP, STAMP_MAX, OFFSET_MAX);
      send_beat(OP_LAST, '0, '0);
      send_beat(OP_LOOKUP, TIME_W'(STAMP_MAX % PERIOD), '0);
      send_beat(OP_LOOKUP, 31'd100, '0);    // never written
      for (int k = 0; k < 8; k++) begin
         send_beat(OP_INSERT, TIME_W'(PERIOD * 2 + 100 + k), pick_offset());
      end
   endtask

   task automatic test_no_idling();
      run_phase(0, 0, 8'd1, 300);
   endtask

   task automatic test_sender_idle();
      run_phase(87, 0, 8'd255, 300);
   endtask

   task automatic test_receiver_stall();
      run_phase(0, 87, 8'd0, 300);
   endtask

   task automatic test_both_idle();
      run_phase(8, 8, COUNT_W'($urandom_range(2, 254)), 300);
   endtask

   // long result hold-off while requests keep coming: the block must fill
   // up and push back on the request side
   task automatic test_backpressure();
      pause_until_drained();
      write_flush(8'd7);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left <= 300;
      repeat (25) random_beat();
   endtask

   // request side goes quiet until the pipe is empty, then resumes
   task automatic test_drain_pause();
      send_idle_pct = 20;
      recv_stall_pct = 20;
      repeat (12) random_beat();
      pause_until_drained();
      repeat (12) random_beat();
   endtask

   // highest slot of the day, held back until now
   task automatic test_top_slot();
      pause_until_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_beat(OP_INSERT, TIME_W'(PERIOD - 1), OFFSET_MAX);
      send_beat(OP_LAST, '0, '0);
      send_beat(OP_LOOKUP, TIME_W'(PERIOD - 1), '0);
      send_beat(OP_FIRST, '0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall, or a counted hold-off when one is pending.
   // The test only arms hold_left while it is zero, so the two writers
   // never collide in one step.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // every taken result beat is matched against the oldest prediction
   always @(posedge clock) begin
      seek_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("%0t: result beat with nothing pending, status %0d",
                        $time, rsp_status);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_status !== want.status || rsp_found_time !== want.found_stamp ||
                rsp_found_offset !== want.found_offs ||
                rsp_persist_request !== want.persist) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("%0t: result %0d mismatch (expected / actual)", $time,
                           results_checked);
                  $display("   status %0d / %0d, persist %0d / %0d", want.status,
                           rsp_status, want.persist, rsp_persist_request);
                  $display("   time %0d / %0d", want.found_stamp, rsp_found_time);
                  $display("   offset %0d / %0d", want.found_offs, rsp_found_offset);
               end
            end
         end
      end
   end

   // watchdog, sized for the clear pass plus the slowest stimulus
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      hot_slot[0] = 1;
      hot_slot[1] = 2;
      for (int k = 2; k < HOT_SLOTS; k++) hot_slot[k] = $urandom_range(3, PERIOD / 4);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // the clear pass holds req_stall high; send_beat just waits it out
      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      test_drain_pause();
      test_top_slot();
      pause_until_drained();
      $display("sent %0d beats over four idling mixes, a long result hold-off and a drain pause;",
               beats_sent);
      $display("checked %0d results, %0d of them persist requests, %0d failures",
               results_checked, persists_due, fail_count);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
